### hdl/signed_integer_to_decimal_ascii_defines.svh
// Assertion macros used by the checker file.
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define SITDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define SITDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/sitda_pkg.sv
package sitda_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned PADW_W     = 5;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 20;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 8'd45;
  localparam logic [DIGIT_W-1:0] DABBLE_THRESH = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD    = 4'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     bit_in;
  } chain_ctrl_t;

endpackage

### hdl/sitda_if.sv
interface sitda_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sitda_pkg::VALUE_W-1:0] value;
  logic        [sitda_pkg::PADW_W-1:0]  pad_width;

  modport source (output valid, value, pad_width, input ready);
  modport sink   (input valid, value, pad_width, output ready);
endinterface

interface sitda_out_if;
  logic                         valid;
  logic                         ready;
  logic [sitda_pkg::CHAR_W-1:0] ascii_char;
  logic                         is_last;

  modport source (output valid, ascii_char, is_last, input ready);
  modport sink   (input valid, ascii_char, is_last, output ready);
endinterface

### hdl/sitda_bcd_cell.sv
module sitda_bcd_cell (
  input  logic                            clk_i,
  input  sitda_pkg::cell_op_e             op_i,
  input  logic                            bit_i,
  input  logic [sitda_pkg::DIGIT_W-1:0]   digit_i,
  output logic                            bit_o,
  output logic [sitda_pkg::DIGIT_W-1:0]   digit_o
);
  import sitda_pkg::*;

  logic [DIGIT_W-1:0] digit_q, digit_d, adj;

  assign adj     = (digit_q >= DABBLE_THRESH) ? digit_q + DABBLE_ADD : digit_q;
  assign bit_o   = adj[DIGIT_W-1];
  assign digit_o = digit_q;

  always_comb begin
    case (op_i)
      CELL_HOLD:   digit_d = digit_q;
      CELL_CLEAR:  digit_d = '0;
      CELL_DABBLE: digit_d = {adj[DIGIT_W-2:0], bit_i};
      CELL_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

### hdl/sitda_digit_chain.sv
module sitda_digit_chain (
  input  logic                          clk_i,
  input  sitda_pkg::chain_ctrl_t        ctrl_i,
  output logic [sitda_pkg::DIGIT_W-1:0] top_digit_o
);
  import sitda_pkg::*;

  logic [DIGIT_W-1:0] digits [NUM_DIGITS];
  logic               carry  [NUM_DIGITS-1];

  assign top_digit_o = digits[NUM_DIGITS-1];

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    if (k == 0) begin : g_low
      sitda_bcd_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (ctrl_i.op),
        .bit_i   (ctrl_i.bit_in),
        .digit_i ('0),
        .bit_o   (carry[k]),
        .digit_o (digits[k])
      );
    end else if (k == NUM_DIGITS-1) begin : g_top
      sitda_bcd_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (ctrl_i.op),
        .bit_i   (carry[k-1]),
        .digit_i (digits[k-1]),
        .bit_o   (),
        .digit_o (digits[k])
      );
    end else begin : g_mid
      sitda_bcd_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (ctrl_i.op),
        .bit_i   (carry[k-1]),
        .digit_i (digits[k-1]),
        .bit_o   (carry[k]),
        .digit_o (digits[k])
      );
    end
  end

endmodule

### hdl/signed_integer_to_decimal_ascii.sv
// After acceptance the magnitude bits are shifted through the BCD cell chain, leading zero
// digits are dropped (at least one digit stays), the padding is sized, and then the sign,
// pad zeros and digits are registered one character at a time as the output slot frees.
// The next number is taken in the cycle after the last character is registered.
// Reset (asynchronous, active low) returns the controller to idle and empties the output.
module signed_integer_to_decimal_ascii #(
  parameter int unsigned MAX_CHARS = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  sitda_in_if.sink    in_i,
  sitda_out_if.source out_o
);
  import sitda_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CHARS);
  localparam int unsigned BIT_W = $clog2(VALUE_W);
  localparam int unsigned ND_W  = $clog2(NUM_DIGITS + 1);
  localparam logic [CNT_W-1:0] CHAR_CAP = CNT_W'(MAX_CHARS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_PAD   = 3'd4;
  localparam logic [2:0] ST_DIGIT = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [VALUE_W-1:0] mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [PADW_W-1:0]  width_q, width_d;
  logic [BIT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [ND_W-1:0]    ndig_q, ndig_d;
  logic [CNT_W-1:0]   pad_q, pad_d;
  logic               ov_q, ov_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;

  logic [DIGIT_W-1:0] top_digit;
  chain_ctrl_t        ctrl;
  logic               accept, slot_free, push, push_last;
  logic [CHAR_W-1:0]  push_char;
  logic [CNT_W-1:0]   natural, width_ext, total_a, total_b, total, pad_calc;

  sitda_digit_chain u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .top_digit_o (top_digit)
  );

  assign in_i.ready       = (state_q == ST_IDLE);
  assign accept           = in_i.valid && in_i.ready;
  assign slot_free        = !ov_q || out_o.ready;
  assign out_o.valid      = ov_q;
  assign out_o.ascii_char = char_q;
  assign out_o.is_last    = last_q;

  assign natural   = CNT_W'(ndig_q) + CNT_W'(neg_q);
  assign width_ext = CNT_W'(width_q);
  assign total_a   = (width_ext > natural) ? width_ext : natural;
  assign total_b   = (total_a > CHAR_CAP) ? CHAR_CAP : total_a;
  assign total     = (total_b < natural) ? natural : total_b;
  assign pad_calc  = total - natural;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    width_d     = width_q;
    bit_cnt_d   = bit_cnt_q;
    ndig_d      = ndig_q;
    pad_d       = pad_q;
    ctrl.op     = CELL_HOLD;
    ctrl.bit_in = mag_q[VALUE_W-1];
    push        = 1'b0;
    push_char   = CHAR_ZERO;
    push_last   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          neg_d     = in_i.value[VALUE_W-1];
          mag_d     = in_i.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_i.value))
                                            : VALUE_W'(in_i.value);
          width_d   = in_i.pad_width;
          bit_cnt_d = '0;
          ctrl.op   = CELL_CLEAR;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.op   = CELL_DABBLE;
        mag_d     = {mag_q[VALUE_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + BIT_W'(1);
        if (bit_cnt_q == BIT_W'(VALUE_W - 1)) begin
          ndig_d  = ND_W'(NUM_DIGITS);
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (ndig_q > ND_W'(1) && top_digit == '0) begin
          ctrl.op = CELL_SHIFT;
          ndig_d  = ndig_q - ND_W'(1);
        end else begin
          pad_d = pad_calc;
          if (neg_q) begin
            state_d = ST_SIGN;
          end else if (pad_calc != '0) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          push      = 1'b1;
          push_char = CHAR_MINUS;
          state_d   = (pad_q != '0) ? ST_PAD : ST_DIGIT;
        end
      end
      ST_PAD: begin
        if (slot_free) begin
          push  = 1'b1;
          pad_d = pad_q - CNT_W'(1);
          if (pad_q == CNT_W'(1)) begin
            state_d = ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          push      = 1'b1;
          push_char = CHAR_ZERO + CHAR_W'(top_digit);
          push_last = (ndig_q == ND_W'(1));
          ctrl.op   = CELL_SHIFT;
          ndig_d    = ndig_q - ND_W'(1);
          if (ndig_q == ND_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d   = ov_q;
    char_d = char_q;
    last_d = last_q;
    if (push) begin
      ov_d   = 1'b1;
      char_d = push_char;
      last_d = push_last;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    width_q   <= width_d;
    bit_cnt_q <= bit_cnt_d;
    ndig_q    <= ndig_d;
    pad_q     <= pad_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

endmodule

### hdl/sitda_checker.sv
`include "signed_integer_to_decimal_ascii_defines.svh"

module sitda_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [sitda_pkg::CHAR_W-1:0] out_char_i,
  input logic                         out_last_i
);
  import sitda_pkg::*;

  `SITDA_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(out_last_i), "stalled output transaction changed")
  `SITDA_ASSERT(a_char_set, out_valid_i |-> out_char_i == CHAR_MINUS || (out_char_i >= CHAR_ZERO && out_char_i <= CHAR_ZERO + 8'd9), "character outside sign and digits")
  `SITDA_ASSERT(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i, "input taken while converting")
  `SITDA_ASSERT(a_sign_not_last, out_valid_i && out_char_i == CHAR_MINUS |-> !out_last_i, "sign flagged as last character")
  `SITDA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_i, "output valid during reset")

endmodule

bind signed_integer_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.ascii_char),
  .out_last_i  (out_o.is_last)
);
